>>> sv/drnm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package drnm_pkg;

   // Field widths.
   localparam int ETA_W    = 13;
   localparam int PHI_W    = 12;
   localparam int PT_W     = 16;
   localparam int DIST_W   = 27;
   localparam int IDX_W    = 6;
   localparam int OP_W     = 2;
   localparam int ENTRY_W  = ETA_W + PHI_W + PT_W;

   // Stored entry layout, lowest bits first: eta, phi, pt.
   localparam int ETA_LSB  = 0;
   localparam int PHI_LSB  = ETA_W;
   localparam int PT_LSB   = ETA_W + PHI_W;

   // Half a turn of azimuth in angle units.
   localparam logic [PHI_W-1:0] PHI_HALF = PHI_W'(2048);

   // Distance limit after reset: no limit.
   localparam logic [DIST_W-1:0] MAX_DIST_RESET = '1;

   localparam int MAX_MUONS_DEFAULT = 64;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   // One candidate leaving the distance pipeline.
   typedef struct packed {
      logic              valid;
      logic [DIST_W-1:0] dist_sq;
      logic [ETA_W-1:0]  eta;
      logic [PT_W-1:0]   pt;
   } drnm_cand_type;

endpackage

`default_nettype wire

>>> sv/drnm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module drnm_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> sv/drnm_dist.sv
`timescale 1ns / 1ps
`default_nettype none

module drnm_dist (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                rd_valid,
   input  wire logic [drnm_pkg::ENTRY_W-1:0]        rd_entry,
   input  wire logic [drnm_pkg::ETA_W-1:0]          q_eta,
   input  wire logic [drnm_pkg::PHI_W-1:0]          q_phi,
   output drnm_pkg::drnm_cand_type                  cand,
   output logic                                     busy
);

   import drnm_pkg::*;

   localparam int EDIFF_W = ETA_W + 1;
   localparam int SQE_W   = 2 * ETA_W;
   localparam int SQP_W   = 2 * PHI_W;

   logic [ETA_W-1:0]   m_eta;
   logic [PHI_W-1:0]   m_phi;
   logic [PT_W-1:0]    m_pt;
   logic [EDIFF_W-1:0] de;
   logic [EDIFF_W-1:0] de_neg;
   logic [PHI_W-1:0]   phi_diff;

   // Stage A: absolute differences.
   logic               a_valid_ff, a_valid_in;
   logic [ETA_W-1:0]   a_ade_ff, a_ade_in;
   logic [PHI_W-1:0]   a_dp_ff, a_dp_in;
   logic [ETA_W-1:0]   a_eta_ff;
   logic [PT_W-1:0]    a_pt_ff;

   // Stage B: squares.
   logic               b_valid_ff;
   logic [SQE_W-1:0]   b_sqe_ff, b_sqe_in;
   logic [SQP_W-1:0]   b_sqp_ff, b_sqp_in;
   logic [ETA_W-1:0]   b_eta_ff;
   logic [PT_W-1:0]    b_pt_ff;

   // Stage C: sum.
   drnm_cand_type      cand_ff, cand_in;

   assign m_eta = rd_entry[ETA_LSB +: ETA_W];
   assign m_phi = rd_entry[PHI_LSB +: PHI_W];
   assign m_pt  = rd_entry[PT_LSB +: PT_W];

   always_comb begin
      de       = {q_eta[ETA_W-1], q_eta} - {m_eta[ETA_W-1], m_eta};
      de_neg   = (~de) + EDIFF_W'(1);
      a_ade_in = de[EDIFF_W-1] ? de_neg[ETA_W-1:0] : de[ETA_W-1:0];
      // The azimuth difference wraps around the turn and folds into half a turn.
      phi_diff = q_phi - m_phi;
      a_dp_in  = (phi_diff > PHI_HALF) ? ((~phi_diff) + PHI_W'(1)) : phi_diff;
      a_valid_in = rd_valid;
      b_sqe_in = a_ade_ff * a_ade_ff;
      b_sqp_in = a_dp_ff * a_dp_ff;
      cand_in.valid   = b_valid_ff;
      cand_in.dist_sq = DIST_W'(b_sqe_ff) + DIST_W'(b_sqp_ff);
      cand_in.eta     = b_eta_ff;
      cand_in.pt      = b_pt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         cand_ff.valid <= 1'b0;
      end else begin
         a_valid_ff    <= a_valid_in;
         b_valid_ff    <= a_valid_ff;
         cand_ff.valid <= cand_in.valid;
      end
      a_ade_ff        <= a_ade_in;
      a_dp_ff         <= a_dp_in;
      a_eta_ff        <= m_eta;
      a_pt_ff         <= m_pt;
      b_sqe_ff        <= b_sqe_in;
      b_sqp_ff        <= b_sqp_in;
      b_eta_ff        <= a_eta_ff;
      b_pt_ff         <= a_pt_ff;
      cand_ff.dist_sq <= cand_in.dist_sq;
      cand_ff.eta     <= cand_in.eta;
      cand_ff.pt      <= cand_in.pt;
   end

   assign cand = cand_ff;
   assign busy = a_valid_ff | b_valid_ff;

endmodule

`default_nettype wire

>>> sv/delta_r_nearest_match.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake        Contents
// req_      in         tvalid/tready    clear, load or query word
// rsp_      out        tvalid/tready    one result word per muon query
// csr_      in/out     APB              max_distance_sq at byte address 0
//
// Clear and load words leave the controller idle. A muon query blocks the
// request channel until its result is formed; its scan is paced by the
// single read port of the muon store: one stored muon is read and compared
// per cycle.
// The store holds no valid bits; only entries below the fill count are read.
// Reset is synchronous and clears the fill count, the controller and the
// result slot. A result waiting in the output register does not block the
// next word; only a finished query that finds the slot still full waits.

module delta_r_nearest_match #(
   parameter int MAX_MUONS = drnm_pkg::MAX_MUONS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: obj_eta[12:0], obj_phi[24:13], obj_pt[40:25], zero [47:41].
   input  wire logic [47:0] req_tdata,
   // tuser: opcode[1:0], is_muon_object[2].
   input  wire logic [2:0]  req_tuser,
   // Response channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: best_index[5:0], best_pt[21:6], best_eta[34:22],
   //        best_distance_sq[61:35], zero [63:62].
   output logic [63:0]      rsp_tdata,
   // tuser: match_found[0].
   output logic [0:0]       rsp_tuser,
   // Configuration port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   import drnm_pkg::*;

   localparam int CNT_W  = $clog2(MAX_MUONS + 1);
   localparam int ADDR_W = (MAX_MUONS > 1) ? $clog2(MAX_MUONS) : 1;
   localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(MAX_MUONS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // Request fields.
   logic [OP_W-1:0]  req_opcode;
   logic [ETA_W-1:0] req_eta;
   logic [PHI_W-1:0] req_phi;
   logic [PT_W-1:0]  req_pt;
   logic             req_is_muon;
   logic             req_fire;

   assign req_eta     = req_tdata[ETA_LSB +: ETA_W];
   assign req_phi     = req_tdata[PHI_LSB +: PHI_W];
   assign req_pt      = req_tdata[PT_LSB +: PT_W];
   assign req_opcode  = req_tuser[OP_W-1:0];
   assign req_is_muon = req_tuser[OP_W];

   // Control state.
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  scan_addr_ff, scan_addr_in;
   logic              s1_valid_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0] max_dist_ff, max_dist_in;

   // Query and running best.
   logic [ETA_W-1:0]  q_eta_ff, q_eta_in;
   logic [PHI_W-1:0]  q_phi_ff, q_phi_in;
   logic [ADDR_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic              best_found_ff, best_found_in;
   logic [ADDR_W-1:0] best_idx_ff, best_idx_in;
   logic [DIST_W-1:0] best_dist_ff, best_dist_in;
   logic [ETA_W-1:0]  best_eta_ff, best_eta_in;
   logic [PT_W-1:0]   best_pt_ff, best_pt_in;

   // Output register.
   logic              rsp_match_ff, rsp_match_in;
   logic [IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [PT_W-1:0]   rsp_pt_ff, rsp_pt_in;
   logic [ETA_W-1:0]  rsp_eta_ff, rsp_eta_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;

   // Store ports and the distance pipeline.
   logic               mem_wr_en;
   logic [ENTRY_W-1:0] mem_wr_data;
   logic               mem_rd_en;
   logic [ENTRY_W-1:0] mem_rd_data;
   drnm_cand_type      cand;
   logic               dist_busy;
   logic               slot_free;
   logic               csr_write;

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_fire    = req_tvalid & req_tready;
   assign slot_free   = ~rsp_valid_ff | rsp_tready;
   assign mem_wr_data = {req_pt, req_phi, req_eta};

   // The limit is written only on the single register's word address.
   assign csr_write   = csr_psel & csr_penable & csr_pwrite & csr_pready & ~csr_paddr[2];
   assign csr_pready  = 1'b1;
   assign csr_prdata  = csr_paddr[2] ? 32'd0 : 32'(max_dist_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_addr_in  = scan_addr_ff;
      q_eta_in      = q_eta_ff;
      q_phi_in      = q_phi_ff;
      cmp_idx_in    = cmp_idx_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_dist_in  = best_dist_ff;
      best_eta_in   = best_eta_ff;
      best_pt_in    = best_pt_ff;
      rsp_match_in  = rsp_match_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_pt_in     = rsp_pt_ff;
      rsp_eta_in    = rsp_eta_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      max_dist_in   = csr_write ? csr_pwdata[DIST_W-1:0] : max_dist_ff;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_opcode)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_LOAD: begin
                     // A load into a full store is dropped.
                     if (count_ff < COUNT_FULL) begin
                        mem_wr_en = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  OP_QUERY: begin
                     if (req_is_muon) begin
                        state_in      = ST_SCAN;
                        scan_addr_in  = '0;
                        cmp_idx_in    = '0;
                        q_eta_in      = req_eta;
                        q_phi_in      = req_phi;
                        best_found_in = 1'b0;
                        best_dist_in  = max_dist_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            mem_rd_en = (scan_addr_ff < count_ff);
            if (mem_rd_en) begin
               scan_addr_in = scan_addr_ff + CNT_W'(1);
            end
            // Candidates arrive in store order, so a strict compare keeps the
            // first of several equal distances.
            if (cand.valid) begin
               cmp_idx_in = cmp_idx_ff + ADDR_W'(1);
               if (cand.dist_sq < best_dist_ff) begin
                  best_found_in = 1'b1;
                  best_idx_in   = cmp_idx_ff;
                  best_dist_in  = cand.dist_sq;
                  best_eta_in   = cand.eta;
                  best_pt_in    = cand.pt;
               end
            end
            if (!mem_rd_en && !s1_valid_ff && !dist_busy && !cand.valid) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_match_in = best_found_ff;
               rsp_idx_in   = best_found_ff ? IDX_W'(best_idx_ff) : '0;
               rsp_pt_in    = best_found_ff ? best_pt_ff : '0;
               rsp_eta_in   = best_found_ff ? best_eta_ff : '0;
               rsp_dist_in  = best_found_ff ? best_dist_ff : '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_addr_ff <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_dist_ff  <= MAX_DIST_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_addr_ff <= scan_addr_in;
         s1_valid_ff  <= mem_rd_en;
         rsp_valid_ff <= rsp_valid_in;
         max_dist_ff  <= max_dist_in;
      end
      q_eta_ff      <= q_eta_in;
      q_phi_ff      <= q_phi_in;
      cmp_idx_ff    <= cmp_idx_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_dist_ff  <= best_dist_in;
      best_eta_ff   <= best_eta_in;
      best_pt_ff    <= best_pt_in;
      rsp_match_ff  <= rsp_match_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_pt_ff     <= rsp_pt_in;
      rsp_eta_ff    <= rsp_eta_in;
      rsp_dist_ff   <= rsp_dist_in;
   end

   // Muon store: written at the fill count, read at the scan address.
   drnm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_MUONS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (scan_addr_ff[ADDR_W-1:0]),
      .rd_data (mem_rd_data)
   );

   drnm_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .rd_valid (s1_valid_ff),
      .rd_entry (mem_rd_data),
      .q_eta    (q_eta_ff),
      .q_phi    (q_phi_ff),
      .cand     (cand),
      .busy     (dist_busy)
   );

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_match_ff;
   assign rsp_tdata    = {2'b00, rsp_dist_ff, rsp_eta_ff, rsp_pt_ff, rsp_idx_ff};

   // The fill count never passes the store depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= COUNT_FULL)
      else $error("muon count beyond store depth");

   // The scan never reads past the filled part of the store.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_addr_ff <= count_ff))
      else $error("scan address beyond fill count");

   // A result is only formed once every candidate has been compared.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (!s1_valid_ff && !dist_busy && !cand.valid))
      else $error("result formed with candidates in flight");

   // A result without a match carries all-zero fields.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == 64'd0))
      else $error("no-match result with nonzero fields");

endmodule

`default_nettype wire

>>> tb/sv/delta_r_nearest_match_test.sv
`timescale 1ns / 1ps

module delta_r_nearest_match_test;
   import drnm_pkg::*;

   localparam int STORE_DEPTH = MAX_MUONS_DEFAULT;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [2:0] LIMIT_ADDR = 3'd0;
   localparam logic [ETA_W-1:0] ETA_MIN = 13'h1000;   // -4096
   localparam logic [ETA_W-1:0] ETA_MAX = 13'h0FFF;   // +4095
   localparam logic [DIST_W-1:0] FARTHEST = 27'd71286785;
   localparam int SETTLE_CYCLES = 120;
   localparam int RANDOM_WORDS = 400;

   typedef struct packed {
      logic              found;
      logic [IDX_W-1:0]  index;
      logic [PT_W-1:0]   pt;
      logic [ETA_W-1:0]  eta;
      logic [DIST_W-1:0] dist_sq;
   } match_result_type;

   // Mirrors the muon store and the distance limit, and keeps the answers
   // still owed by the block in order.
   class nearest_match_predictor;
      logic [ETA_W-1:0]  st_eta[STORE_DEPTH];
      logic [PHI_W-1:0]  st_phi[STORE_DEPTH];
      logic [PT_W-1:0]   st_pt[STORE_DEPTH];
      int                fill;
      logic [DIST_W-1:0] dist_limit;
      match_result_type  pending_matches[$];
      int                errors;
      int                n_answers;
      int                n_hits;
      int                n_dropped_loads;

      function new();
         fill = 0;
         dist_limit = MAX_DIST_RESET;
         errors = 0;
         n_answers = 0;
         n_hits = 0;
         n_dropped_loads = 0;
      endfunction

      function logic [DIST_W-1:0] delta_r_sq(logic [ETA_W-1:0] eta_a, logic [PHI_W-1:0] phi_a,
                                             logic [ETA_W-1:0] eta_b, logic [PHI_W-1:0] phi_b);
         int de;
         logic [PHI_W-1:0] dp_raw;
         int dp;
         de = int'($signed(eta_a)) - int'($signed(eta_b));
         if (de < 0) de = -de;
         dp_raw = phi_a - phi_b;
         dp = int'(dp_raw);
         if (dp > 2048) dp = 4096 - dp;
         return DIST_W'(de * de + dp * dp);
      endfunction

      function void note_word(logic [OP_W-1:0] op, logic [ETA_W-1:0] eta,
                              logic [PHI_W-1:0] phi, logic [PT_W-1:0] pt, logic muon);
         match_result_type r;
         logic [DIST_W-1:0] best;
         logic [DIST_W-1:0] d;
         int best_i;
         case (op)
            OP_CLEAR: begin
               fill = 0;
            end
            OP_LOAD: begin
               if (fill < STORE_DEPTH) begin
                  st_eta[fill] = eta;
                  st_phi[fill] = phi;
                  st_pt[fill] = pt;
                  fill++;
               end else begin
                  n_dropped_loads++;
               end
            end
            OP_QUERY: begin
               if (muon) begin
                  best = dist_limit;
                  best_i = -1;
                  for (int i = 0; i < fill; i++) begin
                     d = delta_r_sq(eta, phi, st_eta[i], st_phi[i]);
                     if (d < best) begin
                        best = d;
                        best_i = i;
                     end
                  end
                  r = '0;
                  if (best_i >= 0) begin
                     r.found = 1'b1;
                     r.index = IDX_W'(best_i);
                     r.pt = st_pt[best_i];
                     r.eta = st_eta[best_i];
                     r.dist_sq = best;
                  end
                  pending_matches.insert(pending_matches.size(), r);
               end
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_match(logic [63:0] data, logic [0:0] user);
         match_result_type want;
         if (pending_matches.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word, expected none, actual tdata %0h tuser %0h",
                     $time, data, user);
            return;
         end
         want = pending_matches.pop_front();
         n_answers++;
         if (want.found) n_hits++;
         compare_field("match_found", 32'(want.found), 32'(user[0]));
         compare_field("best_index", 32'(want.index), 32'(data[5:0]));
         compare_field("best_pt", 32'(want.pt), 32'(data[21:6]));
         compare_field("best_eta", 32'(want.eta), 32'(data[34:22]));
         compare_field("best_distance_sq", 32'(want.dist_sq), 32'(data[61:35]));
      endfunction

      function int pending();
         return pending_matches.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic calm = 1'b0;
   nearest_match_predictor board;
   int words_sent;

   delta_r_nearest_match DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // The receiver stalls at random except during the calm stretch.
   always @(posedge clock) begin
      rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 17);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_match(rsp_tdata, rsp_tuser);
   end

   task automatic send_word(input logic [OP_W-1:0] op, input logic [ETA_W-1:0] eta,
                            input logic [PHI_W-1:0] phi, input logic [PT_W-1:0] pt,
                            input logic muon);
      while (!calm && $urandom_range(99) < 17) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'b0, pt, phi, eta};
      req_tuser <= {muon, op};
      do @(posedge clock); while (!req_tready);
      board.note_word(op, eta, phi, pt, muon);
      words_sent++;
   endtask

   // Waits until every owed answer is in, then lets a query that gives no
   // answer run out of the block.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the distance limit and reads it back.
   task automatic write_limit(input logic [DIST_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= LIMIT_ADDR;
      csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.dist_limit = value;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.compare_field("max_distance_sq readback", 32'(value), csr_prdata);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic random_word_in_phase();
      int r;
      int i;
      int de;
      int dp;
      r = $urandom_range(99);
      if (r < 60 && board.fill > 0) begin
         // Query close to a stored muon; phi may wrap across zero.
         i = $urandom_range(board.fill - 1);
         de = ($urandom_range(9) == 0) ? 0 : int'($urandom_range(400)) - 200;
         dp = ($urandom_range(9) == 0) ? 0 : int'($urandom_range(400)) - 200;
         send_word(OP_QUERY, board.st_eta[i] + ETA_W'(de), board.st_phi[i] + PHI_W'(dp),
                   PT_W'($urandom), 1'b1);
      end else if (r < 80) begin
         send_word(OP_QUERY, ETA_W'($urandom), PHI_W'($urandom), PT_W'($urandom), 1'b1);
      end else if (r < 88) begin
         send_word(OP_QUERY, ETA_W'($urandom), PHI_W'($urandom), PT_W'($urandom), 1'b0);
      end else if (r < 93) begin
         send_word(OP_UNUSED, ETA_W'($urandom), PHI_W'($urandom), PT_W'($urandom),
                   1'($urandom));
      end else begin
         send_word(OP_LOAD, ETA_W'($urandom), PHI_W'($urandom), PT_W'($urandom),
                   1'($urandom));
      end
   endtask

   initial begin
      int phase;
      int n_loads;
      int n_queries;
      logic [DIST_W-1:0] limit;
      logic [ETA_W-1:0] eta;
      logic [PHI_W-1:0] phi;

      board = new();
      words_sent = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, starting at the reset limit.
      send_word(OP_QUERY, 13'd0, 12'd0, 16'd0, 1'b1);          // empty store
      send_word(OP_LOAD, ETA_MIN, 12'd0, 16'd0, 1'b0);
      send_word(OP_LOAD, ETA_MAX, 12'hFFF, 16'hFFFF, 1'b1);
      send_word(OP_LOAD, 13'd0, PHI_HALF, 16'h5555, 1'b0);
      send_word(OP_LOAD, 13'd0, PHI_HALF, 16'hAAAA, 1'b0);     // same place: tie
      send_word(OP_QUERY, 13'd0, PHI_HALF, 16'd0, 1'b1);
      send_word(OP_QUERY, ETA_MAX, 12'd1, 16'hFFFF, 1'b1);     // phi wraps
      send_word(OP_QUERY, ETA_MIN, 12'hFFF, 16'd0, 1'b1);
      send_word(OP_QUERY, 13'd0, PHI_HALF, 16'd0, 1'b0);       // not a muon
      send_word(OP_UNUSED, ETA_MAX, 12'hFFF, 16'hFFFF, 1'b1);
      send_word(OP_CLEAR, ETA_MAX, 12'hFFF, 16'hFFFF, 1'b1);
      send_word(OP_QUERY, 13'd0, PHI_HALF, 16'd0, 1'b1);       // after clear
      send_word(OP_LOAD, ETA_MIN, 12'd0, 16'd1, 1'b0);
      send_word(OP_QUERY, ETA_MAX, PHI_HALF, 16'd0, 1'b1);     // farthest possible
      settle();
      write_limit(FARTHEST);
      send_word(OP_QUERY, ETA_MAX, PHI_HALF, 16'd0, 1'b1);     // equal to limit: no match
      settle();
      write_limit(FARTHEST + 1'b1);
      send_word(OP_QUERY, ETA_MAX, PHI_HALF, 16'd0, 1'b1);
      settle();
      write_limit('0);
      send_word(OP_QUERY, ETA_MIN, 12'd0, 16'd0, 1'b1);        // exact position, zero limit: no match
      settle();
      write_limit(27'd1);
      send_word(OP_QUERY, ETA_MIN, 12'd0, 16'd0, 1'b1);
      send_word(OP_QUERY, ETA_MIN, 12'd1, 16'd0, 1'b1);

      // Random phases: clear, fill the store, then mostly nearby queries.
      phase = 0;
      while (words_sent < RANDOM_WORDS) begin
         settle();
         calm <= (phase == 2);
         case (phase % 7)
            0: limit = MAX_DIST_RESET;
            1: limit = '0;
            2: limit = DIST_W'($urandom_range(200000));
            3: limit = FARTHEST;
            4: limit = DIST_W'($urandom_range(40000));
            5: limit = 27'd1;
            default: limit = DIST_W'($urandom);
         endcase
         write_limit(limit);
         send_word(OP_CLEAR, ETA_W'($urandom), PHI_W'($urandom), PT_W'($urandom),
                   1'($urandom));
         n_loads = (phase % 5 == 4) ? STORE_DEPTH + int'($urandom_range(1, 4))
                                    : int'($urandom_range(1, 12));
         eta = ETA_W'($urandom);
         phi = PHI_W'($urandom);
         for (int k = 0; k < n_loads; k++) begin
            // Now and then repeat the last muon so that ties come up.
            if ($urandom_range(9) != 0) begin
               eta = ETA_W'($urandom);
               phi = PHI_W'($urandom);
            end
            send_word(OP_LOAD, eta, phi, PT_W'($urandom), 1'($urandom));
            if ($urandom_range(9) == 0) random_word_in_phase();
         end
         n_queries = $urandom_range(6, 16);
         for (int k = 0; k < n_queries; k++) begin
            if (k == n_queries / 2 && board.pending() > 0) begin
               req_tvalid <= 1'b0;
               while (board.pending() > 0) @(posedge clock);
            end
            random_word_in_phase();
         end
         phase++;
      end

      settle();
      $display("Covered %0d words in %0d random phases; %0d answers checked, %0d matched.",
               words_sent, phase, board.n_answers, board.n_hits);
      $display("Loads dropped on a full store: %0d.", board.n_dropped_loads);
      if (board.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
